[hdl/ibt_pkg.sv]
// ibt_pkg: shared constants, codes and controller interface types
// for the interval booking table. no dependencies.

package ibt_pkg;

  localparam int CAPACITY    = 64;
  localparam int TIME_BITS   = 32;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ENTRY_W     = 2 * TIME_BITS;
  localparam int FIELD_W     = 32;
  localparam int ECOUNT_W    = 7;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    STAT_BOOKED  = 2'd0,
    STAT_OVERLAP = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_INVALID = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic shift;
    logic write_new;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic invalid;
    logic scan_busy;
    logic overlap;
    logic full;
    logic insert_at_end;
    logic shift_busy;
    logic out_free;
  } ctrl_stat_t;

endpackage

[hdl/ibt_ram.sv]
// ibt_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module ibt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/ibt_datapath.sv]
// ibt_datapath: request registers, interval store, scan compare, shift insert
// and result register. depends on ibt_pkg and ibt_ram

module ibt_datapath import ibt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [FIELD_W-1:0]  in_start_time,
  input  logic [FIELD_W-1:0]  in_end_time,
  input  ctrl_cmd_t           cmd,
  output ctrl_stat_t          stat,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic                out_booked,
  output status_t             out_status,
  output logic [ECOUNT_W-1:0] out_entry_count
);

  logic [TIME_BITS-1:0] start_r, end_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     idx_r, k_r, pos_r;
  logic                 cmp_valid_r, cmp_valid_nxt;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 ovl_r, pos_found_r, booked_r;
  logic                 wr_pend_r, wr_pend_nxt;
  logic [IDX_W-1:0]     wr_addr_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_booked_r;
  status_t              out_status_r;
  logic [ECOUNT_W-1:0]  out_count_r;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
  logic [TIME_BITS-1:0] rd_start, rd_end;
  logic                 rd_issue, sh_issue, hit, at_or_after;
  status_t              result_code;

  ibt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_start    = ram_rdata[TIME_BITS-1:0];
  assign rd_end      = ram_rdata[ENTRY_W-1:TIME_BITS];
  assign hit         = (start_r < rd_end) && (rd_start < end_r);
  assign at_or_after = rd_start >= start_r;

  assign rd_issue = cmd.scan && (idx_r < count_r);
  assign sh_issue = cmd.shift && (k_r > pos_r);

  always_comb begin
    ram_raddr = idx_r[IDX_W-1:0];
    if (cmd.shift) begin
      ram_raddr = IDX_W'(k_r - CNT_W'(1));
    end
  end

  // shifted copies and the new entry never share a cycle
  always_comb begin
    ram_we    = wr_pend_r || cmd.write_new;
    ram_waddr = wr_addr_r;
    ram_wdata = ram_rdata;
    if (cmd.write_new) begin
      ram_waddr = pos_r[IDX_W-1:0];
      ram_wdata = {end_r, start_r};
    end
  end

  always_comb begin
    priority if (end_r <= start_r) begin
      result_code = STAT_INVALID;
    end else if (ovl_r) begin
      result_code = STAT_OVERLAP;
    end else if (booked_r) begin
      result_code = STAT_BOOKED;
    end else begin
      result_code = STAT_FULL;
    end
  end

  always_comb begin
    count_nxt     = cmd.write_new ? count_r + CNT_W'(1) : count_r;
    cmp_valid_nxt = rd_issue;
    wr_pend_nxt   = sh_issue;
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r     <= in_start_time[TIME_BITS-1:0];
      end_r       <= in_end_time[TIME_BITS-1:0];
      idx_r       <= '0;
      k_r         <= count_r;
      pos_r       <= count_r;
      ovl_r       <= 1'b0;
      pos_found_r <= 1'b0;
      booked_r    <= 1'b0;
    end else begin
      if (rd_issue) begin
        idx_r     <= idx_r + CNT_W'(1);
        cmp_idx_r <= idx_r[IDX_W-1:0];
      end
      if (cmp_valid_r) begin
        if (hit) begin
          ovl_r <= 1'b1;
        end
        if (at_or_after && !pos_found_r) begin
          pos_r       <= CNT_W'(cmp_idx_r);
          pos_found_r <= 1'b1;
        end
      end
      if (sh_issue) begin
        wr_addr_r <= k_r[IDX_W-1:0];
        k_r       <= k_r - CNT_W'(1);
      end
      if (cmd.write_new) begin
        booked_r <= 1'b1;
      end
    end
    if (cmd.emit) begin
      out_booked_r <= (result_code == STAT_BOOKED);
      out_status_r <= result_code;
      out_count_r  <= ECOUNT_W'(count_r);
    end
  end

  always_comb begin
    stat.invalid       = end_r <= start_r;
    stat.scan_busy     = (idx_r < count_r) || cmp_valid_r;
    stat.overlap       = ovl_r;
    stat.full          = count_r >= CNT_W'(CAPACITY);
    stat.insert_at_end = pos_r == count_r;
    stat.shift_busy    = (k_r > pos_r) || wr_pend_r;
    stat.out_free      = !out_valid_r || out_tready;
  end

  assign out_tvalid      = out_valid_r;
  assign out_booked      = out_booked_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

endmodule

[hdl/ibt_ctrl.sv]
// ibt_ctrl: request sequencer for scan, shift, insert and result hand-off
// depends on ibt_pkg

module ibt_ctrl import ibt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (stat.invalid) begin
          state_nxt = S_DONE;
        end else if (stat.scan_busy) begin
          state_nxt = S_SCAN;
        end else if (stat.overlap || stat.full) begin
          state_nxt = S_DONE;
        end else if (stat.insert_at_end) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!stat.shift_busy) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_SCAN: begin
        cmd.scan = !stat.invalid;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
      end
      S_WRITE: begin
        cmd.write_new = 1'b1;
      end
      S_DONE: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hdl/interval_booking_table_core.sv]
// interval_booking_table_core: top level of the interval booking table
// depends on ibt_pkg, ibt_ctrl, ibt_datapath and ibt_ram

// Books half-open intervals [start, end) into a table kept sorted by start.
// Each request gives one result: booked, or rejected as overlap, table full or
// invalid (end not after start), with the entry count after the request.
// One request is worked at a time. A valid request scans the stored entries
// through the store's single registered read port, then, if booked in front of
// later entries, moves each of them up one place, then writes the new entry;
// a held result can delay the hand-off. The result sits in an output register,
// so a new request is taken while the last result waits.

module interval_booking_table_core import ibt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [31:0] start_time, [63:32] end_time
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] booked, [2:1] status, [9:3] entry_count, [15:10] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  ctrl_cmd_t           cmd;
  ctrl_stat_t          stat;
  logic                res_booked;
  status_t             res_status;
  logic [ECOUNT_W-1:0] res_count;

  ibt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ibt_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_start_time   (in_tdata[FIELD_W-1:0]),
    .in_end_time     (in_tdata[2*FIELD_W-1:FIELD_W]),
    .cmd             (cmd),
    .stat            (stat),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_booked      (res_booked),
    .out_status      (res_status),
    .out_entry_count (res_count)
  );

  assign out_tdata = {(OUT_TDATA_W - ECOUNT_W - 3)'(0), res_count, res_status, res_booked};

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while another is in work");

  a_booked_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_booked == (res_status == STAT_BOOKED)))
    else $error("booked flag disagrees with status");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_count <= ECOUNT_W'(CAPACITY)))
    else $error("entry count beyond capacity");

endmodule

[tb/interval_booking_table_core_test.sv]
`timescale 1ns / 1ps
// interval_booking_table_core_test: self-checking bench for the interval booking table.
// predicts each request against its own sorted table and checks every result in order.
// depends on ibt_pkg and interval_booking_table_core.

module interval_booking_table_core_test;
  import ibt_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 20;
  localparam longint unsigned TIME_TOP = (64'd1 << TIME_BITS) - 1;

  typedef struct {
    logic                booked;
    status_t             status;
    logic [ECOUNT_W-1:0] entry_count;
  } booking_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // own copy of the booking table, sorted by start
  logic [TIME_BITS-1:0] table_start [CAPACITY];
  logic [TIME_BITS-1:0] table_end [CAPACITY];
  int table_count;

  booking_result_t expected_bookings_q[$];
  int status_seen [4];
  int requests_sent;
  int results_seen;
  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int ready_hold_left;

  interval_booking_table_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned below(input longint unsigned n);
    return {$urandom, $urandom} % n;
  endfunction

  function automatic longint unsigned min_of(input longint unsigned a, input longint unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic booking_result_t predict_booking(input logic [TIME_BITS-1:0] s,
                                                      input logic [TIME_BITS-1:0] e);
    booking_result_t r;
    logic hit;
    int pos;
    int k;
    hit = 1'b0;
    for (k = 0; k < table_count; k++)
      if (s < table_end[k] && table_start[k] < e) hit = 1'b1;
    if (e <= s) begin
      r.status = STAT_INVALID;
    end else if (hit) begin
      r.status = STAT_OVERLAP;
    end else if (table_count >= CAPACITY) begin
      r.status = STAT_FULL;
    end else begin
      pos = 0;
      while (pos < table_count && table_start[pos] < s) pos++;
      for (k = table_count; k > pos; k--) begin
        table_start[k] = table_start[k-1];
        table_end[k]   = table_end[k-1];
      end
      table_start[pos] = s;
      table_end[pos]   = e;
      table_count++;
      r.status = STAT_BOOKED;
    end
    r.booked      = (r.status == STAT_BOOKED);
    r.entry_count = ECOUNT_W'(table_count);
    status_seen[int'(r.status)]++;
    return r;
  endfunction

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endfunction

  // one request; valid stays high into the next call unless that call idles
  task automatic send_request(input logic [TIME_BITS-1:0] s, input logic [TIME_BITS-1:0] e);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {FIELD_W'(e), FIELD_W'(s)};
    do @(posedge clk); while (!in_tready);
    expected_bookings_q.push_back(predict_booking(s, e));
    requests_sent++;
  endtask

  task automatic send_random_pair();
    send_request(TIME_BITS'($urandom), TIME_BITS'($urandom));
  endtask

  task automatic send_invalid();
    longint unsigned s;
    s = TIME_BITS'($urandom);
    send_request(TIME_BITS'(s), TIME_BITS'(s - below(s + 1)));
  endtask

  // free interval in a random gap, often touching a neighbour
  task automatic send_gap_booking();
    int gaps[$];
    int k;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned s;
    longint unsigned e;
    longint unsigned span;
    for (k = 0; k <= table_count; k++) begin
      lo = (k == 0) ? 0 : table_end[k-1];
      hi = (k == table_count) ? TIME_TOP : table_start[k];
      if (hi > lo) gaps.push_back(k);
    end
    if (gaps.size() == 0) begin
      send_random_pair();
      return;
    end
    k = gaps[$urandom_range(gaps.size() - 1)];
    lo = (k == 0) ? 0 : table_end[k-1];
    hi = (k == table_count) ? TIME_TOP : table_start[k];
    span = ($urandom_range(3) == 0) ? hi - lo : 64'd1000;
    if ($urandom_range(2) == 0) s = lo;
    else s = lo + below(min_of(hi - lo, span));
    if ($urandom_range(2) == 0) e = hi;
    else e = s + 1 + below(min_of(hi - s, span));
    send_request(TIME_BITS'(s), TIME_BITS'(e));
  endtask

  // interval that shares at least one point with a stored one
  task automatic send_overlap();
    int j;
    longint unsigned p;
    longint unsigned s;
    longint unsigned e;
    longint unsigned span;
    if (table_count == 0) begin
      send_gap_booking();
      return;
    end
    j = $urandom_range(table_count - 1);
    p = table_start[j] + below(table_end[j] - table_start[j]);
    span = $urandom_range(1) ? 64'd1000 : TIME_TOP;
    s = p - below(min_of(p, span) + 1);
    e = p + 1 + below(min_of(TIME_TOP - (p + 1), span) + 1);
    send_request(TIME_BITS'(s), TIME_BITS'(e));
  endtask

  task automatic test_invalid_intervals();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request('0, '0);
    send_request('1, '0);
    send_request(5, 5);
    send_request('1, '1);
    send_request(32'h8000_0000, 32'h7FFF_FFFF);
  endtask

  task automatic test_extreme_bookings();
    send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(0, 1);
  endtask

  task automatic test_touching_and_overlap();
    send_request(1, 100);
    send_request(100, 200);
    send_request(50, 60);
    send_request(199, 201);
    send_request(0, 32'hFFFF_FFFF);
    send_request(1000, 2000);
    send_request(999, 1001);
    send_request(2000, 2001);
    send_request(1999, 2000);
    send_request(32'hFFFF_FFFD, 32'hFFFF_FFFE);
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_back_pressure();
    int n;
    in_tvalid <= 1'b0;
    @(negedge clk) ready_hold_left = 400;
    @(posedge clk);
    for (n = 0; n < 16; n++) begin
      if ($urandom_range(1)) send_overlap();
      else send_invalid();
    end
  endtask

  task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
    int n;
    int pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 10) send_gap_booking();
      else if (pick < 50) send_overlap();
      else if (pick < 62) send_invalid();
      else send_random_pair();
    end
  endtask

  // fill up, then a free request (full), a colliding one (overlap wins) and another free one
  task automatic test_table_full();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (table_count < CAPACITY) send_gap_booking();
    send_gap_booking();
    send_overlap();
    send_gap_booking();
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_bookings_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_hold_left > 0) begin
      out_tready <= 1'b0;
      ready_hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    booking_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_bookings_q.size() == 0) begin
        note_mismatch($sformatf("result %h with no request outstanding", out_tdata));
      end else begin
        want = expected_bookings_q.pop_front();
        if (out_tdata[0] !== want.booked || out_tdata[2:1] !== want.status ||
            out_tdata[9:3] !== want.entry_count)
          note_mismatch($sformatf(
            "result %0d expected booked %0d status %0d count %0d, got booked %0d status %0d count %0d",
            results_seen, want.booked, want.status, want.entry_count,
            out_tdata[0], out_tdata[2:1], out_tdata[9:3]));
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    out_tready      = 1'b0;
    table_count     = 0;
    requests_sent   = 0;
    results_seen    = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    ready_hold_left = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_invalid_intervals();
    test_extreme_bookings();
    test_touching_and_overlap();
    test_back_pressure();
    test_random_traffic(270, 0, 0);
    test_random_traffic(270, 87, 0);
    test_table_full();
    test_random_traffic(270, 0, 87);
    test_random_traffic(270, 26, 26);

    in_tvalid      <= 1'b0;
    recv_stall_pct = 0;
    while (expected_bookings_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests over %0d cycles: %0d booked, %0d overlapping, %0d refused as full,",
             requests_sent, cycle_count, status_seen[STAT_BOOKED], status_seen[STAT_OVERLAP],
             status_seen[STAT_FULL]);
    $display("%0d invalid; %0d results checked, %0d mismatches", status_seen[STAT_INVALID],
             results_seen, mismatch_count);
    if (mismatch_count == 0 && expected_bookings_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
